### rtl/hpd_pkg.sv
// Shared constants and types for the Horner polynomial and derivative evaluator.
package hpd_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_COEFFS = 6;
    localparam int MAX_DERIVS = 4;
    localparam int NUM_CELLS  = MAX_COEFFS - 1;

    localparam int ORD_W  = 2;
    localparam int REG_W  = 3;
    localparam int CNT_W  = $clog2(MAX_COEFFS + 1);
    localparam int KW     = $clog2(MAX_DERIVS + 1);
    localparam int GAP_W  = (MAX_DERIVS > 1) ? $clog2(MAX_DERIVS) : 1;
    localparam int CIDX_W = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    localparam int ADDR_W = 5;

    localparam int PROD_W = 2 * DATA_W;
    localparam int RND_W  = 2 * DATA_W - FRAC_BITS;
    localparam int SUM_W  = RND_W + 2;

    localparam logic signed [PROD_W-1:0] ROUND_ADD =
        (FRAC_BITS == 0) ? '0 : (PROD_W'(1) << (FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

    localparam logic [REG_W-1:0] REG_COEFF_COUNT = 3'd0;
    localparam logic [REG_W-1:0] REG_COEFF_FIRST = 3'd1;
    localparam logic [REG_W-1:0] REG_COEFF_LAST  = 3'd6;
    localparam logic [REG_W-1:0] REG_DERIV_COUNT = 3'd7;

    localparam logic ERR_NONE     = 1'b0;
    localparam logic ERR_NO_COEFF = 1'b1;

    typedef struct packed {
        logic                                 valid;
        logic                                 err;
        logic [DATA_W-1:0]                    x;
        logic [MAX_DERIVS-1:0][DATA_W-1:0]    d;
        logic [MAX_DERIVS-1:0]                ovf;
    } t_cell_bus;

endpackage

### rtl/hpd_cell.sv
// One Horner step cell: multiplies in the first stage, rounds, adds and saturates in the second.
module hpd_cell import hpd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_active,
    input  logic signed [DATA_W-1:0] i_coeff,
    input  t_cell_bus                i_bus,
    output t_cell_bus                o_bus
);

    t_cell_bus                r_a_bus;
    t_cell_bus                n_a_bus;
    logic signed [PROD_W-1:0] r_prod [MAX_DERIVS];
    t_cell_bus                r_b_bus;
    t_cell_bus                n_b_bus;

    logic signed [PROD_W-1:0] rnd_full [MAX_DERIVS];
    logic signed [SUM_W-1:0]  addend   [MAX_DERIVS];
    logic signed [SUM_W-1:0]  sum      [MAX_DERIVS];
    logic [MAX_DERIVS-1:0]    sat;
    logic [DATA_W-1:0]        sat_val  [MAX_DERIVS];

    always_comb begin
        n_a_bus = i_bus;
        if (!i_rst_n) begin
            n_a_bus.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_bus <= n_a_bus;
        for (int j = 0; j < MAX_DERIVS; j++) begin
            r_prod[j] <= $signed(i_bus.x) * $signed(i_bus.d[j]);
        end
    end

    always_comb begin
        addend[0] = SUM_W'(i_coeff);
        for (int j = 1; j < MAX_DERIVS; j++) begin
            addend[j] = SUM_W'($signed(r_a_bus.d[j-1])) * SUM_W'(j);
        end
        for (int j = 0; j < MAX_DERIVS; j++) begin
            rnd_full[j] = (r_prod[j] + ROUND_ADD) >>> FRAC_BITS;
            sum[j]      = addend[j] + SUM_W'($signed(rnd_full[j][RND_W-1:0]));
            if (sum[j] > SAT_HI) begin
                sat[j]     = 1'b1;
                sat_val[j] = VAL_MAX;
            end else if (sum[j] < SAT_LO) begin
                sat[j]     = 1'b1;
                sat_val[j] = VAL_MIN;
            end else begin
                sat[j]     = 1'b0;
                sat_val[j] = sum[j][DATA_W-1:0];
            end
        end

        n_b_bus = r_a_bus;
        if (i_active) begin
            n_b_bus.d[0]   = sat_val[0];
            n_b_bus.ovf[0] = r_a_bus.ovf[0] | sat[0];
            for (int j = 1; j < MAX_DERIVS; j++) begin
                n_b_bus.d[j]   = sat_val[j];
                n_b_bus.ovf[j] = r_a_bus.ovf[j] | r_a_bus.ovf[j-1] | sat[j];
            end
        end
        if (!i_rst_n) begin
            n_b_bus.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_bus <= n_b_bus;
    end

    assign o_bus = r_b_bus;

endmodule

### rtl/hpd_serializer.sv
// Output serializer that emits the value and the derivatives of one point in rising order.
module hpd_serializer import hpd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_bus         i_bus,
    input  logic [KW-1:0]     i_k,
    output logic              o_strobe,
    output logic [ORD_W-1:0]  o_order,
    output logic [DATA_W-1:0] o_value,
    output logic              o_ovf,
    output logic              o_err,
    output logic              o_last
);

    logic                              r_run;
    logic [ORD_W-1:0]                  r_ord;
    logic [MAX_DERIVS-1:0][DATA_W-1:0] r_hold_d;
    logic [MAX_DERIVS-1:0]             r_hold_ovf;
    logic                              r_strobe;
    logic [ORD_W-1:0]                  r_order;
    logic [DATA_W-1:0]                 r_value;
    logic                              r_ovf;
    logic                              r_err;
    logic                              r_last;

    logic                              n_run;
    logic [ORD_W-1:0]                  n_ord;
    logic                              n_strobe;
    logic [ORD_W-1:0]                  n_order;
    logic [DATA_W-1:0]                 n_value;
    logic                              n_ovf;
    logic                              n_err;
    logic                              n_last;

    always_comb begin
        n_run    = r_run;
        n_ord    = r_ord;
        n_strobe = 1'b0;
        n_order  = r_ord;
        n_value  = r_hold_d[r_ord];
        n_ovf    = r_hold_ovf[r_ord];
        n_err    = ERR_NONE;
        n_last   = 1'b0;
        if (i_bus.valid) begin
            n_strobe = 1'b1;
            n_order  = '0;
            n_err    = i_bus.err;
            n_value  = i_bus.err ? '0 : i_bus.d[0];
            n_ovf    = i_bus.err ? 1'b0 : i_bus.ovf[0];
            n_last   = i_bus.err || (i_k == KW'(1));
            n_run    = !n_last;
            n_ord    = ORD_W'(1);
        end else if (r_run) begin
            n_strobe = 1'b1;
            n_last   = (KW'(r_ord) == i_k - KW'(1));
            n_run    = !n_last;
            n_ord    = r_ord + ORD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bus.valid) begin
            r_hold_d   <= i_bus.d;
            r_hold_ovf <= i_bus.ovf;
        end
        r_order <= n_order;
        r_value <= n_value;
        r_ovf   <= n_ovf;
        r_err   <= n_err;
        r_last  <= n_last;
        r_ord   <= n_ord;
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_run    <= n_run;
            r_strobe <= n_strobe;
        end
    end

    assign o_strobe = r_strobe;
    assign o_order  = r_order;
    assign o_value  = r_value;
    assign o_ovf    = r_ovf;
    assign o_err    = r_err;
    assign o_last   = r_last;

endmodule

### rtl/polynomial_horner_with_derivatives_core.sv
// Top level of the Horner polynomial evaluator with first to third derivatives.
// Results of a transaction leave the result ports in rising order, one per cycle. o_busy
// holds off a new transaction until the one before has had the port for its k results,
// k being the effective derivative count (1 to 4), so the single result port never overruns.
// Reset is synchronous and active low; it clears the valid flags of the pipeline, the
// coefficient count and the coefficients, and sets the derivative count to 1.
module polynomial_horner_with_derivatives_core import hpd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [DATA_W-1:0] i_x_value,
    output logic                     o_strobe,
    output logic [ORD_W-1:0]         o_deriv_order,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic                     o_overflow,
    output logic                     o_error_code,
    output logic                     o_last,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [REG_W-1:0]         r_coeff_count;
    logic signed [DATA_W-1:0] r_coeff [MAX_COEFFS];
    logic [REG_W-1:0]         r_deriv_count;
    logic [GAP_W-1:0]         r_gap;

    logic [REG_W-1:0]  reg_idx;
    logic              cfg_wr;
    logic [CNT_W-1:0]  n_eff;
    logic [KW-1:0]     k_eff;
    logic              accept;
    t_cell_bus         entry_bus;
    t_cell_bus         chain [NUM_CELLS+1];
    logic [DATA_W-1:0] ser_value;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_count <= '0;
            r_deriv_count <= REG_W'(1);
            for (int i = 0; i < MAX_COEFFS; i++) begin
                r_coeff[i] <= '0;
            end
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_COEFF_COUNT: r_coeff_count <= pwdata[REG_W-1:0];
                REG_DERIV_COUNT: r_deriv_count <= pwdata[REG_W-1:0];
                default: begin
                    if (reg_idx >= REG_COEFF_FIRST && reg_idx <= REG_COEFF_LAST) begin
                        r_coeff[CIDX_W'(reg_idx - REG_COEFF_FIRST)] <= pwdata[DATA_W-1:0];
                    end
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COEFF_COUNT: prdata = 32'(r_coeff_count);
            REG_DERIV_COUNT: prdata = 32'(r_deriv_count);
            default: begin
                if (reg_idx >= REG_COEFF_FIRST && reg_idx <= REG_COEFF_LAST) begin
                    prdata = r_coeff[CIDX_W'(reg_idx - REG_COEFF_FIRST)];
                end else begin
                    prdata = '0;
                end
            end
        endcase
    end

    always_comb begin
        if (r_coeff_count > REG_W'(MAX_COEFFS)) begin
            n_eff = CNT_W'(MAX_COEFFS);
        end else begin
            n_eff = CNT_W'(r_coeff_count);
        end
        if (r_deriv_count == '0) begin
            k_eff = KW'(1);
        end else if (r_deriv_count > REG_W'(MAX_DERIVS)) begin
            k_eff = KW'(MAX_DERIVS);
        end else begin
            k_eff = KW'(r_deriv_count);
        end
    end

    assign o_busy = (r_gap != '0);
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (accept) begin
            r_gap <= GAP_W'(k_eff - KW'(1));
        end else if (r_gap != '0) begin
            r_gap <= r_gap - GAP_W'(1);
        end
    end

    always_comb begin
        entry_bus       = '0;
        entry_bus.valid = accept;
        entry_bus.err   = (n_eff == '0) ? ERR_NO_COEFF : ERR_NONE;
        entry_bus.x     = i_x_value;
        if (n_eff != '0) begin
            entry_bus.d[0] = r_coeff[CIDX_W'(n_eff - CNT_W'(1))];
        end
    end

    assign chain[0] = entry_bus;

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        localparam int CoeffIdx = NUM_CELLS - 1 - c;
        hpd_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_active (n_eff >= CNT_W'(CoeffIdx + 2)),
            .i_coeff  (r_coeff[CoeffIdx]),
            .i_bus    (chain[c]),
            .o_bus    (chain[c+1])
        );
    end

    hpd_serializer u_serializer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bus    (chain[NUM_CELLS]),
        .i_k      (k_eff),
        .o_strobe (o_strobe),
        .o_order  (o_deriv_order),
        .o_value  (ser_value),
        .o_ovf    (o_overflow),
        .o_err    (o_error_code),
        .o_last   (o_last)
    );

    assign o_result_value = ser_value;

endmodule

### test/hpd_result_checker.sv
// Checker that predicts and compares the results of the Horner polynomial evaluator.
module hpd_result_checker import hpd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic signed [DATA_W-1:0] i_x_value,
    input  logic                     i_strobe,
    input  logic [ORD_W-1:0]         i_deriv_order,
    input  logic signed [DATA_W-1:0] i_result_value,
    input  logic                     i_overflow,
    input  logic                     i_error_code,
    input  logic                     i_last,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic                     i_pready,
    input  logic [ADDR_W-1:0]        i_paddr,
    input  logic [31:0]              i_pwdata,
    output int                       o_fail_count,
    output int                       o_owed
);

    typedef struct packed {
        logic [ORD_W-1:0]  order;
        logic [DATA_W-1:0] value;
        logic              ovf;
        logic              err;
        logic              last;
    } t_deriv_result;

    logic [REG_W-1:0]         coeff_cnt_q;
    logic [REG_W-1:0]         deriv_cnt_q;
    logic signed [DATA_W-1:0] coeff_q [MAX_COEFFS];
    t_deriv_result            owed_results [$];
    t_deriv_result            want;

    function automatic longint scaled_product(input logic signed [DATA_W-1:0] a,
                                              input logic signed [DATA_W-1:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return (p + ROUND_ADD) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [DATA_W-1:0] saturate(input longint v, output logic hit);
        longint hi;
        longint lo;
        hi = longint'($signed(VAL_MAX));
        lo = longint'($signed(VAL_MIN));
        hit = (v > hi) || (v < lo);
        if (v > hi) begin
            return $signed(VAL_MAX);
        end else if (v < lo) begin
            return $signed(VAL_MIN);
        end
        return DATA_W'(v);
    endfunction

    function automatic void evaluate_point(input logic signed [DATA_W-1:0] xv);
        logic signed [DATA_W-1:0] d [MAX_DERIVS];
        logic                     ovf [MAX_DERIVS];
        logic                     hit;
        longint                   acc;
        int                       n;
        int                       k;
        t_deriv_result            r;
        n = (coeff_cnt_q > MAX_COEFFS) ? MAX_COEFFS : int'(coeff_cnt_q);
        k = (deriv_cnt_q == 0) ? 1 :
            ((deriv_cnt_q > MAX_DERIVS) ? MAX_DERIVS : int'(deriv_cnt_q));
        if (n == 0) begin
            r.order = '0;
            r.value = '0;
            r.ovf   = 1'b0;
            r.err   = ERR_NO_COEFF;
            r.last  = 1'b1;
            owed_results = {owed_results, r};
            return;
        end
        for (int j = 0; j < MAX_DERIVS; j++) begin
            d[j]   = '0;
            ovf[j] = 1'b0;
        end
        d[0] = coeff_q[n-1];
        for (int i = n - 2; i >= 0; i--) begin
            for (int j = k - 1; j > 0; j--) begin
                acc    = longint'(j) * longint'(d[j-1]) + scaled_product(xv, d[j]);
                d[j]   = saturate(acc, hit);
                ovf[j] = ovf[j] | ovf[j-1] | hit;
            end
            acc    = longint'(coeff_q[i]) + scaled_product(xv, d[0]);
            d[0]   = saturate(acc, hit);
            ovf[0] = ovf[0] | hit;
        end
        for (int j = 0; j < k; j++) begin
            r.order = ORD_W'(j);
            r.value = d[j];
            r.ovf   = ovf[j];
            r.err   = ERR_NONE;
            r.last  = (j == k - 1);
            owed_results = {owed_results, r};
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] exp_val);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, exp_val);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coeff_cnt_q = '0;
            deriv_cnt_q = REG_W'(1);
            for (int i = 0; i < MAX_COEFFS; i++) begin
                coeff_q[i] = '0;
            end
            owed_results.delete();
        end else begin
            if (i_strobe) begin
                if (owed_results.size() == 0) begin
                    flag_mismatch("unexpected result", i_result_value, '0);
                end else begin
                    want = owed_results.pop_front();
                    if (i_deriv_order !== want.order) begin
                        flag_mismatch("deriv_order", DATA_W'(i_deriv_order),
                                      DATA_W'(want.order));
                    end
                    if (i_result_value !== want.value) begin
                        flag_mismatch("result_value", i_result_value, want.value);
                    end
                    if (i_overflow !== want.ovf) begin
                        flag_mismatch("overflow", DATA_W'(i_overflow), DATA_W'(want.ovf));
                    end
                    if (i_error_code !== want.err) begin
                        flag_mismatch("error_code", DATA_W'(i_error_code), DATA_W'(want.err));
                    end
                    if (i_last !== want.last) begin
                        flag_mismatch("last", DATA_W'(i_last), DATA_W'(want.last));
                    end
                end
            end
            if (i_start && !i_busy) begin
                evaluate_point(i_x_value);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_COEFF_COUNT: begin
                        coeff_cnt_q = i_pwdata[REG_W-1:0];
                    end
                    REG_DERIV_COUNT: begin
                        deriv_cnt_q = i_pwdata[REG_W-1:0];
                    end
                    default: begin
                        coeff_q[i_paddr[ADDR_W-1:2] - REG_COEFF_FIRST] = i_pwdata;
                    end
                endcase
            end
        end
        o_owed <= owed_results.size();
    end

endmodule

### test/polynomial_horner_with_derivatives_core_tb.sv
// Testbench top for the Horner polynomial evaluator: stimulus, register setup and verdict.
module polynomial_horner_with_derivatives_core_tb;
    import hpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic signed [DATA_W-1:0] i_x_value;
    logic                     o_strobe;
    logic [ORD_W-1:0]         o_deriv_order;
    logic signed [DATA_W-1:0] o_result_value;
    logic                     o_overflow;
    logic                     o_error_code;
    logic                     o_last;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    int                       mismatch_count;
    int                       owed_count;
    int                       stall_cycles;
    logic [DATA_W-1:0]        coeff_plan [MAX_COEFFS];

    polynomial_horner_with_derivatives_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_x_value      (i_x_value),
        .o_strobe       (o_strobe),
        .o_deriv_order  (o_deriv_order),
        .o_result_value (o_result_value),
        .o_overflow     (o_overflow),
        .o_error_code   (o_error_code),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    hpd_result_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_x_value      (i_x_value),
        .i_strobe       (o_strobe),
        .i_deriv_order  (o_deriv_order),
        .i_result_value (o_result_value),
        .i_overflow     (o_overflow),
        .i_error_code   (o_error_code),
        .i_last         (o_last),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (mismatch_count),
        .o_owed         (owed_count)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
        end else if (sel < 8) begin
            return $urandom;
        end else if (sel == 8) begin
            case ($urandom_range(0, 3))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
    endfunction

    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (owed_count != 0) @(posedge i_clk);
    endtask

    // The block is quiet once every owed result is back; a short settle follows anyway.
    task automatic load_config(input logic [31:0] cnt, input logic [31:0] derivs);
        i_start <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_COEFF_COUNT, cnt);
        for (int i = 0; i < MAX_COEFFS; i++) begin
            write_reg(REG_COEFF_FIRST + REG_W'(i), coeff_plan[i]);
        end
        write_reg(REG_DERIV_COUNT, derivs);
    endtask

    task automatic send_point(input logic [DATA_W-1:0] xv, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_x_value <= xv;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    initial begin
        int idle_pct;
        i_rst_n   <= 1'b0;
        i_start   <= 1'b0;
        i_x_value <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_point('0, 0);
        send_point(VAL_MAX, 0);

        for (int i = 0; i < MAX_COEFFS; i++) coeff_plan[i] = 32'h0001_0000 + 32'(i);
        load_config(0, 4);
        send_point(VAL_MIN, 0);

        for (int i = 0; i < MAX_COEFFS; i++) coeff_plan[i] = 32'h0001_0000;
        load_config(7, 7);
        send_point(32'h0001_0000, 0);
        send_point(32'hFFFF_0000, 0);
        i_start <= 1'b0;
        wait_drained();
        send_point('0, 0);
        send_point(32'h0000_8000, 0);
        send_point(VAL_MAX, 0);
        send_point(VAL_MIN, 0);

        coeff_plan[0] = VAL_MIN;
        load_config(1, 0);
        send_point(32'h1234_5678, 0);
        send_point('1, 0);

        for (int i = 0; i < MAX_COEFFS; i++) coeff_plan[i] = (i % 2 == 0) ? VAL_MAX : VAL_MIN;
        load_config(6, 4);
        send_point(32'h0001_0000, 0);
        send_point(32'hFFFF_0000, 0);
        send_point(32'h0000_0001, 0);
        send_point('1, 0);

        coeff_plan[0] = '0;
        coeff_plan[1] = '1;
        load_config(2, 2);
        send_point(32'h0000_8000, 0);
        send_point(32'h0001_8000, 0);

        for (int round = 0; round < 12; round++) begin
            idle_pct = (round < 4) ? 7 : ((round < 8) ? 76 : 0);
            for (int i = 0; i < MAX_COEFFS; i++) coeff_plan[i] = pick_value();
            load_config($urandom_range(0, 7), $urandom_range(0, 7));
            repeat ($urandom_range(20, 32)) begin
                if ($urandom_range(0, 99) < 2) begin
                    i_start <= 1'b0;
                    wait_drained();
                end
                send_point(pick_value(), idle_pct);
            end
        end

        i_start <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && owed_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### polynomial_horner_with_derivatives_core.f
rtl/hpd_pkg.sv
rtl/hpd_cell.sv
rtl/hpd_serializer.sv
rtl/polynomial_horner_with_derivatives_core.sv
test/hpd_result_checker.sv
test/polynomial_horner_with_derivatives_core_tb.sv
